// ===== design/analog_alarm_hysteresis_deadband_assert.svh =====
// Assertion helpers for the alarm block. Both sample on clk and are
// disabled while arst_n is low.
`ifndef ANALOG_ALARM_HYSTERESIS_DEADBAND_ASSERT_SVH
`define ANALOG_ALARM_HYSTERESIS_DEADBAND_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AAHD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AAHD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/aahd_pkg.sv =====
`timescale 1ns / 1ps

package aahd_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_LIMIT_HIHI       = 3'd0;
	localparam logic [2:0] REG_LIMIT_HIGH       = 3'd1;
	localparam logic [2:0] REG_LIMIT_LOW        = 3'd2;
	localparam logic [2:0] REG_LIMIT_LOLO       = 3'd3;
	localparam logic [2:0] REG_HYSTERESIS       = 3'd4;
	localparam logic [2:0] REG_SEVERITY_SET     = 3'd5;
	localparam logic [2:0] REG_VALUE_DEADBAND   = 3'd6;
	localparam logic [2:0] REG_ARCHIVE_DEADBAND = 3'd7;

	// Alarm status codes
	localparam logic [2:0] STAT_NONE      = 3'd0;
	localparam logic [2:0] STAT_UNDEFINED = 3'd1;
	localparam logic [2:0] STAT_HIHI      = 3'd2;
	localparam logic [2:0] STAT_LOLO      = 3'd3;
	localparam logic [2:0] STAT_HIGH      = 3'd4;
	localparam logic [2:0] STAT_LOW       = 3'd5;

	// Alarm severity codes
	localparam logic [1:0] SEV_NONE    = 2'd0;
	localparam logic [1:0] SEV_INVALID = 2'd3;

	typedef struct packed {
		logic [2:0] status;
		logic [1:0] severity;
	} alarm_t;

	typedef struct packed {
		logic         archive_event;
		logic         value_event;
		logic         alarm_changed;
		logic [1:0]   alarm_severity;
		logic [2:0]   alarm_status;
	} result_t;

endpackage

// ===== design/analog_alarm_hysteresis_deadband.sv =====
`timescale 1ns / 1ps
// A request accepted into the input stage is evaluated there, and its result
// is loaded into the output register once that register may advance, which
// raises m_tvalid.
// Throughput: one request per cycle; the single evaluation stage and the
// output register advance together, so stalls only occur on m_tready low.
// Reset (arst_n low, asynchronous): pipeline empty, all configuration
// registers and all alarm and deadband history cleared to zero.
module analog_alarm_hysteresis_deadband #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [31:0] sample, [34:32] prior_status, [36:35] prior_severity, [39:37] zero
	input  logic [39:0] s_tdata,
	// [0] undefined
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] alarm_status, [4:3] alarm_severity, [5] alarm_changed,
	// [6] value_event, [7] archive_event
	output logic [7:0]  m_tdata
);

	localparam int VW = VALUE_WIDTH;
	// Wide enough for any value plus or minus a 31-bit margin, and for
	// the exact difference of two values.
	localparam int EW = VALUE_WIDTH + 33;

	function automatic logic [VW-1:0] take_value(input logic [31:0] raw);
		logic [VW+31:0] wide;
		wide = {{VW{1'b0}}, raw};
		return wide[VW-1:0];
	endfunction

	function automatic logic signed [EW-1:0] widen(input logic [VW-1:0] v);
		return $signed({{33{v[VW-1]}}, v});
	endfunction

	function automatic logic signed [EW-1:0] widen_u(input logic [30:0] m);
		return $signed({{(EW-31){1'b0}}, m});
	endfunction

	// Configuration registers
	logic [31:0] limit_hihi_q, limit_high_q, limit_low_q, limit_lolo_q;
	logic [30:0] hysteresis_q, value_deadband_q, archive_deadband_q;
	logic [7:0]  severity_set_q;

	// History
	logic [VW-1:0]       last_alarm_q, last_posted_q, last_archived_q;
	aahd_pkg::alarm_t    previous_q;

	// Input stage
	logic                valid_s1;
	logic [VW-1:0]       sample_s1;
	logic                undefined_s1;
	aahd_pkg::alarm_t    prior_s1;

	// Output register
	logic                out_valid_q;
	aahd_pkg::result_t   result_q;

	logic advance;
	logic load_out;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign load_out  = valid_s1 && advance;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_hihi_q       <= '0;
			limit_high_q       <= '0;
			limit_low_q        <= '0;
			limit_lolo_q       <= '0;
			hysteresis_q       <= '0;
			severity_set_q     <= '0;
			value_deadband_q   <= '0;
			archive_deadband_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				aahd_pkg::REG_LIMIT_HIHI:       limit_hihi_q       <= cfg_data;
				aahd_pkg::REG_LIMIT_HIGH:       limit_high_q       <= cfg_data;
				aahd_pkg::REG_LIMIT_LOW:        limit_low_q        <= cfg_data;
				aahd_pkg::REG_LIMIT_LOLO:       limit_lolo_q       <= cfg_data;
				aahd_pkg::REG_HYSTERESIS:       hysteresis_q       <= cfg_data[30:0];
				aahd_pkg::REG_SEVERITY_SET:     severity_set_q     <= cfg_data[7:0];
				aahd_pkg::REG_VALUE_DEADBAND:   value_deadband_q   <= cfg_data[30:0];
				aahd_pkg::REG_ARCHIVE_DEADBAND: archive_deadband_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1         <= take_value(s_tdata[31:0]);
			undefined_s1      <= s_tuser;
			prior_s1.status   <= s_tdata[34:32];
			prior_s1.severity <= s_tdata[36:35];
		end
	end

	// Evaluation
	logic [VW-1:0]          hh, hi, lo, ll;
	logic signed [EW-1:0]   val_e, hh_e, hi_e, lo_e, ll_e, hyst_e;
	logic [1:0]             sev_hh, sev_ll, sev_hi, sev_lo;
	logic                   fire_hh, fire_ll, fire_hi, fire_lo;
	aahd_pkg::alarm_t       alarm_n;
	logic [VW-1:0]          last_alarm_n;
	logic signed [EW-1:0]   post_diff, arch_diff, post_abs, arch_abs;
	logic                   value_ev, archive_ev;

	assign hh     = take_value(limit_hihi_q);
	assign hi     = take_value(limit_high_q);
	assign lo     = take_value(limit_low_q);
	assign ll     = take_value(limit_lolo_q);
	assign val_e  = widen(sample_s1);
	assign hh_e   = widen(hh);
	assign hi_e   = widen(hi);
	assign lo_e   = widen(lo);
	assign ll_e   = widen(ll);
	assign hyst_e = widen_u(hysteresis_q);

	assign sev_hh = severity_set_q[1:0];
	assign sev_ll = severity_set_q[3:2];
	assign sev_hi = severity_set_q[5:4];
	assign sev_lo = severity_set_q[7:6];

	// The limit shifted by the hysteresis never needs clamping here: the
	// sample itself always lies inside the number range.
	assign fire_hh = (sev_hh != aahd_pkg::SEV_NONE) && ((val_e >= hh_e) ||
		((last_alarm_q == hh) && (val_e >= hh_e - hyst_e)));
	assign fire_ll = (sev_ll != aahd_pkg::SEV_NONE) && ((val_e <= ll_e) ||
		((last_alarm_q == ll) && (val_e <= ll_e + hyst_e)));
	assign fire_hi = (sev_hi != aahd_pkg::SEV_NONE) && ((val_e >= hi_e) ||
		((last_alarm_q == hi) && (val_e >= hi_e - hyst_e)));
	assign fire_lo = (sev_lo != aahd_pkg::SEV_NONE) && ((val_e <= lo_e) ||
		((last_alarm_q == lo) && (val_e <= lo_e + hyst_e)));

	always_comb begin
		alarm_n      = prior_s1;
		last_alarm_n = last_alarm_q;
		if (undefined_s1) begin
			if (prior_s1.severity < aahd_pkg::SEV_INVALID) begin
				alarm_n.status   = aahd_pkg::STAT_UNDEFINED;
				alarm_n.severity = aahd_pkg::SEV_INVALID;
			end
		end else if (fire_hh) begin
			if (prior_s1.severity < sev_hh) begin
				alarm_n.status   = aahd_pkg::STAT_HIHI;
				alarm_n.severity = sev_hh;
				last_alarm_n     = hh;
			end
		end else if (fire_ll) begin
			if (prior_s1.severity < sev_ll) begin
				alarm_n.status   = aahd_pkg::STAT_LOLO;
				alarm_n.severity = sev_ll;
				last_alarm_n     = ll;
			end
		end else if (fire_hi) begin
			if (prior_s1.severity < sev_hi) begin
				alarm_n.status   = aahd_pkg::STAT_HIGH;
				alarm_n.severity = sev_hi;
				last_alarm_n     = hi;
			end
		end else if (fire_lo) begin
			if (prior_s1.severity < sev_lo) begin
				alarm_n.status   = aahd_pkg::STAT_LOW;
				alarm_n.severity = sev_lo;
				last_alarm_n     = lo;
			end
		end else begin
			last_alarm_n = sample_s1;
		end
	end

	assign post_diff  = widen(last_posted_q) - val_e;
	assign arch_diff  = widen(last_archived_q) - val_e;
	assign post_abs   = post_diff[EW-1] ? -post_diff : post_diff;
	assign arch_abs   = arch_diff[EW-1] ? -arch_diff : arch_diff;
	assign value_ev   = post_abs > widen_u(value_deadband_q);
	assign archive_ev = arch_abs > widen_u(archive_deadband_q);

	// History moves together with the result, so the next request in the
	// input stage always sees the state left by this one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_alarm_q    <= '0;
			last_posted_q   <= '0;
			last_archived_q <= '0;
			previous_q      <= '0;
		end else if (load_out) begin
			last_alarm_q <= last_alarm_n;
			previous_q   <= alarm_n;
			if (value_ev) begin
				last_posted_q <= sample_s1;
			end
			if (archive_ev) begin
				last_archived_q <= sample_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q.alarm_status   <= alarm_n.status;
			result_q.alarm_severity <= alarm_n.severity;
			result_q.alarm_changed  <= (alarm_n != previous_q);
			result_q.value_event    <= value_ev;
			result_q.archive_event  <= archive_ev;
		end
	end

`include "analog_alarm_hysteresis_deadband_assert.svh"

	`AAHD_ASSERT_SAME(a_accept_when_out_empty, !out_valid_q, s_tready, "input stalled with empty output")
	`AAHD_ASSERT_NEXT(a_undefined_is_invalid, load_out && undefined_s1, result_q.alarm_severity == aahd_pkg::SEV_INVALID, "undefined sample not invalid")
	`AAHD_ASSERT_NEXT(a_severity_not_lowered, load_out, result_q.alarm_severity >= $past(prior_s1.severity), "severity below prior")

endmodule
